### sv/assert_macros.svh
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, off while reset is high.
`define RGBS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds across reset.
`define RGBS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/rgbsobel_pkg.sv
// Types and constants of the RGB-to-grey Sobel edge unit.
package rgbsobel_pkg;

  typedef logic [7:0] pix_t;

  localparam pix_t GREY_R_WT = 8'd77;
  localparam pix_t GREY_G_WT = 8'd150;
  localparam pix_t GREY_B_WT = 8'd29;

  localparam pix_t EDGE_SAT = 8'd255;

  localparam int SUM_W = 21;
  localparam logic [SUM_W-1:0] SAT_LIMIT = 21'd65536;

  localparam int CFG_W = 13;
  localparam int WIDTH_REG_W = 12;
  localparam int ROW_W = 12;
  localparam int HEIGHT_MAX = 4096;
  localparam int DIM_MIN = 3;
  localparam int IMAGE_WIDTH_RESET = 640;
  localparam int IMAGE_HEIGHT_RESET = 480;

  localparam logic REG_IMAGE_WIDTH = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_MULT = 5'b00100,
    S_ROOT = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

endpackage

### sv/rgbsobel_root.sv
// Iterative saturating square root, one result bit per cycle.
module rgbsobel_root
  import rgbsobel_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] sum,
  output logic             busy,
  output pix_t             root
);

  logic [15:0] radicand;
  pix_t        mask;
  pix_t        trial;
  logic [15:0] trial_sq;

  assign trial    = root | mask;
  assign trial_sq = 16'(trial) * 16'(trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      mask <= '0;
    end else if (start) begin
      if (sum >= SAT_LIMIT) begin
        root <= EDGE_SAT;
        busy <= 1'b0;
        mask <= '0;
      end else begin
        root     <= '0;
        radicand <= sum[15:0];
        mask     <= 8'h80;
        busy     <= 1'b1;
      end
    end else if (busy) begin
      if (trial_sq <= radicand) begin
        root <= trial;
      end
      mask <= mask >> 1;
      busy <= ~mask[0];
    end
  end

endmodule

### sv/rgb_to_grey_sobel_edge_unit.sv
// Top level of the RGB-to-grey Sobel 3x3 edge magnitude unit.
//
//   channel   direction  handshake             payload
//   in        sink       in_valid / in_stall   red, green, blue
//   out       source     out_valid / out_stall edge_strength, frame_end
//   cfg       sink       cfg_write             cfg_index, cfg_data
//
// A border pixel is accepted and its line store word read in the idle state and
// written back in the read state. An interior pixel goes through the multiply,
// root and done states; the bit-serial square root, one result bit per cycle,
// is skipped on saturation. Synchronous reset clears the counters, the window
// and out_valid, not the line store. A new pixel is taken while a result waits
// under out_stall; a finished result waits in the done state for a free slot.
module rgb_to_grey_sobel_edge_unit
  import rgbsobel_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       red,
  input  logic [7:0]       green,
  input  logic [7:0]       blue,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       edge_strength,
  output logic             frame_end
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int RESET_W = (IMAGE_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : IMAGE_WIDTH_RESET;
  localparam logic [AW-1:0] RESET_COL_LAST = AW'(RESET_W - 1);
  localparam logic [ROW_W-1:0] RESET_ROW_LAST = ROW_W'(IMAGE_HEIGHT_RESET - 1);

  state_t state;
  state_t state_next;

  logic [AW-1:0]          col;
  logic [ROW_W-1:0]       row;
  logic [AW-1:0]          col_last;
  logic [ROW_W-1:0]       row_last;
  logic [AW-1:0]          col_last_cfg;
  logic [ROW_W-1:0]       row_last_cfg;
  logic [WIDTH_REG_W-1:0] cfg_width;

  logic        in_take;
  logic        slot_free;
  logic [15:0] grey_sum;
  pix_t        grey;

  logic [15:0] line_mem [MAX_WIDTH];
  logic [15:0] rd_word;

  pix_t        taps [3][3];
  pix_t        taps_next [3][3];
  logic [9:0]  gx_pos;
  logic [9:0]  gx_neg;
  logic [9:0]  gy_pos;
  logic [9:0]  gy_neg;
  logic [9:0]  gx_abs;
  logic [9:0]  gy_abs;
  logic [19:0] gx_sq;
  logic [19:0] gy_sq;
  logic [SUM_W-1:0] sq_sum;
  logic        interior;
  logic        last_pix;

  logic        root_busy;
  pix_t        root;

  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && (state == S_IDLE);
  assign slot_free = ~out_valid | ~out_stall;

  // Clamp the width to what the line store can hold and the height to HEIGHT_MAX.
  assign cfg_width = cfg_data[WIDTH_REG_W-1:0];

  always_comb begin
    if (cfg_width < WIDTH_REG_W'(DIM_MIN)) begin
      col_last_cfg = AW'(DIM_MIN - 1);
    end else if (32'(cfg_width) > MAX_WIDTH) begin
      col_last_cfg = AW'(MAX_WIDTH - 1);
    end else begin
      col_last_cfg = AW'(cfg_width - WIDTH_REG_W'(1));
    end
    if (cfg_data < CFG_W'(DIM_MIN)) begin
      row_last_cfg = ROW_W'(DIM_MIN - 1);
    end else if (cfg_data > CFG_W'(HEIGHT_MAX)) begin
      row_last_cfg = ROW_W'(HEIGHT_MAX - 1);
    end else begin
      row_last_cfg = ROW_W'(cfg_data - CFG_W'(1));
    end
  end

  assign grey_sum = 16'(red) * 16'(GREY_R_WT) + 16'(green) * 16'(GREY_G_WT)
                  + 16'(blue) * 16'(GREY_B_WT);

  // Line store word: upper byte two rows up, lower byte one row up.
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      line_mem[col] <= {rd_word[7:0], grey};
    end
    if (in_take) begin
      rd_word <= line_mem[col];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      taps_next[i][0] = taps[i][1];
      taps_next[i][1] = taps[i][2];
    end
    taps_next[0][2] = rd_word[15:8];
    taps_next[1][2] = rd_word[7:0];
    taps_next[2][2] = grey;
  end

  assign gx_pos = 10'(taps_next[0][2]) + 10'({taps_next[1][2], 1'b0}) + 10'(taps_next[2][2]);
  assign gx_neg = 10'(taps_next[0][0]) + 10'({taps_next[1][0], 1'b0}) + 10'(taps_next[2][0]);
  assign gy_pos = 10'(taps_next[2][0]) + 10'({taps_next[2][1], 1'b0}) + 10'(taps_next[2][2]);
  assign gy_neg = 10'(taps_next[0][0]) + 10'({taps_next[0][1], 1'b0}) + 10'(taps_next[0][2]);

  assign gx_sq  = gx_abs * gx_abs;
  assign gy_sq  = gy_abs * gy_abs;
  assign sq_sum = {1'b0, gx_sq} + {1'b0, gy_sq};

  rgbsobel_root u_root (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_MULT),
    .sum   (sq_sum),
    .busy  (root_busy),
    .root  (root)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_take) state_next = S_READ;
      S_READ: state_next = interior ? S_MULT : S_IDLE;
      S_MULT: state_next = S_ROOT;
      S_ROOT: if (!root_busy) state_next = S_DONE;
      S_DONE: if (slot_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign interior = (row >= ROW_W'(2)) && (col >= AW'(2));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      col      <= '0;
      row      <= '0;
      col_last <= RESET_COL_LAST;
      row_last <= RESET_ROW_LAST;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          taps[i][j] <= '0;
        end
      end
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH:  col_last <= col_last_cfg;
          REG_IMAGE_HEIGHT: row_last <= row_last_cfg;
          default:          col_last <= col_last;
        endcase
        col <= '0;
        row <= '0;
      end else if (state == S_READ) begin
        if (col == col_last) begin
          col <= '0;
          row <= (row == row_last) ? '0 : row + ROW_W'(1);
        end else begin
          col <= col + AW'(1);
        end
      end
      if (state == S_READ) begin
        taps <= taps_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      grey <= grey_sum[15:8];
    end
    if (state == S_READ) begin
      gx_abs   <= (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
      gy_abs   <= (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
      last_pix <= (row == row_last) && (col == col_last);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && slot_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && slot_free) begin
      edge_strength <= root;
      frame_end     <= last_pix;
    end
  end

endmodule

### sv/rgbsobel_checker.sv
// Port-level checker for the RGB-to-grey Sobel edge unit, bound to the top level.
`include "assert_macros.svh"

module rgbsobel_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] edge_strength,
  input logic       frame_end
);

  `RGBS_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(edge_strength) && $stable(frame_end), "stalled result changed")
  `RGBS_ASSERT_ALWAYS(a_reset_clears_out, clk, rst |=> !out_valid, "result valid after reset")
  `RGBS_ASSERT(a_one_pixel_at_a_time, clk, rst, in_valid && !in_stall |=> in_stall, "pixel taken while previous pixel in flight")
  `RGBS_ASSERT(a_result_frees_input, clk, rst, $rose(out_valid) |-> $past(in_stall) && !in_stall, "result issued outside the done step")

endmodule

bind rgb_to_grey_sobel_edge_unit rgbsobel_checker u_checker (.*);
